[rtl/sstf_pkg.sv]
package sstf_pkg;

    // table geometry
    localparam int QUEUE_DEPTH = 32;
    localparam int SECTOR_BITS = 48;

    // fixed port widths
    localparam int PORT_SECTOR_W = 48;
    localparam int PENDING_W     = 6;

    // derived widths
    localparam int CUR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // request codes
    typedef enum logic {
        REQ_ADD      = 1'b0,
        REQ_DISPATCH = 1'b1
    } req_type_t;

    typedef logic [SECTOR_BITS-1:0] lba_t;

    // per-cell control from the top level
    typedef struct packed {
        logic add_en;       // insert the broadcast sector this cycle
        logic del_en;       // remove the entry at the cursor this cycle
        logic occupied;     // cell index below entry count
        logic from_cursor;  // cell index at or above the cursor
    } cell_ctl_t;

endpackage

[rtl/sstf_cell.sv]
module sstf_cell (
    input  logic                clk,
    input  sstf_pkg::cell_ctl_t ctl,
    input  sstf_pkg::lba_t      sec,
    input  logic                left_lt,
    input  sstf_pkg::lba_t      left_data,
    input  sstf_pkg::lba_t      right_data,
    output logic                lt,
    output sstf_pkg::lba_t      data,
    output sstf_pkg::lba_t      gap
);

    sstf_pkg::lba_t data_reg;
    sstf_pkg::lba_t data_next;

    // held entry strictly below the new sector
    assign lt   = ctl.occupied && (data_reg < sec);
    // distance to the right neighbor, non-negative since the row is sorted
    assign gap  = right_data - data_reg;
    assign data = data_reg;

    // insert shifts right past the insert point, delete shifts left from cursor
    always_comb
    begin
        data_next = data_reg;
        if (ctl.add_en)
        begin
            if (lt)
                data_next = data_reg;
            else if (left_lt)
                data_next = sec;
            else
                data_next = left_data;
        end
        else if (ctl.del_en && ctl.from_cursor)
        begin
            data_next = right_data;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

[rtl/sstf_request_scheduler_unit.sv]
// Shortest-seek-time-first request scheduler.
// Input channel (in_valid/in_ready) carries req_type and sector. An add
// inserts the sector into a sorted row of cells unless the table is full;
// a dispatch on a non-empty table emits the entry at the cursor, removes it
// and moves the cursor to the closer neighbor (ties go to the higher one).
// Output channel (out_valid/out_ready) carries exactly one result item per
// input item: dispatched, out_sector, add_rejected and pending.
// The result is registered on acceptance and visible in the next cycle.
// Throughput: one item per cycle while results are taken; the whole row
// shifts in the cycle of acceptance, and the next item sees the updated row.
// The input is ready whenever the output register is empty or being
// drained in the same cycle, so a stalled receiver holds the result and
// blocks new items only while that result is not taken.
// Reset empties the table, clears the cursor and the output registers but
// out_sector; no clearing pass is needed, entries past the fill count are never used.
module sstf_request_scheduler_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                req_type,
    input  logic [sstf_pkg::PORT_SECTOR_W-1:0]  sector,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                dispatched,
    output logic [sstf_pkg::PORT_SECTOR_W-1:0]  out_sector,
    output logic                                add_rejected,
    output logic [sstf_pkg::PENDING_W-1:0]      pending
);

    localparam int Depth = sstf_pkg::QUEUE_DEPTH;

    logic [sstf_pkg::CNT_W-1:0] count_reg, count_next;
    logic [sstf_pkg::CUR_W-1:0] cursor_reg, cursor_next;
    logic [sstf_pkg::CUR_W-1:0] cursor_prev;

    logic                       out_valid_reg;
    logic                       dispatched_reg;
    logic                       add_rejected_reg;
    sstf_pkg::lba_t             out_sector_reg;
    logic [sstf_pkg::CNT_W-1:0] pending_reg;

    logic              accept;
    logic              is_add, is_del;
    logic              add_ok, del_ok;
    sstf_pkg::lba_t    sec;

    sstf_pkg::cell_ctl_t ctl  [Depth];
    logic                lt   [Depth];
    sstf_pkg::lba_t      data [Depth];
    sstf_pkg::lba_t      gap  [Depth];

    logic              have_prev, have_next, go_prev;
    sstf_pkg::lba_t    cur_sector;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign sec      = sstf_pkg::SECTOR_BITS'(sector);
    assign is_add   = accept && (req_type == sstf_pkg::REQ_ADD);
    assign is_del   = accept && (req_type == sstf_pkg::REQ_DISPATCH);
    assign add_ok   = is_add && (count_reg < sstf_pkg::CNT_W'(Depth));
    assign del_ok   = is_del && (count_reg != '0);

    // row of cells
    for (genvar i = 0; i < Depth; i++)
    begin : g_cell
        assign ctl[i].add_en      = add_ok;
        assign ctl[i].del_en      = del_ok;
        assign ctl[i].occupied    = (sstf_pkg::CNT_W'(i) < count_reg);
        assign ctl[i].from_cursor = (sstf_pkg::CUR_W'(i) >= cursor_reg);

        if (i == 0)
        begin : g_first
            if (Depth > 1)
            begin : g_more
                sstf_cell u_cell (
                    .clk        (clk),
                    .ctl        (ctl[i]),
                    .sec        (sec),
                    .left_lt    (1'b1),
                    .left_data  (sec),
                    .right_data (data[i+1]),
                    .lt         (lt[i]),
                    .data       (data[i]),
                    .gap        (gap[i])
                );
            end
        end
        else if (i == Depth - 1)
        begin : g_last
            sstf_cell u_cell (
                .clk        (clk),
                .ctl        (ctl[i]),
                .sec        (sec),
                .left_lt    (lt[i-1]),
                .left_data  (data[i-1]),
                .right_data (data[i]),
                .lt         (lt[i]),
                .data       (data[i]),
                .gap        (gap[i])
            );
        end
        else
        begin : g_mid
            sstf_cell u_cell (
                .clk        (clk),
                .ctl        (ctl[i]),
                .sec        (sec),
                .left_lt    (lt[i-1]),
                .left_data  (data[i-1]),
                .right_data (data[i+1]),
                .lt         (lt[i]),
                .data       (data[i]),
                .gap        (gap[i])
            );
        end
    end

    // neighbor choice around the cursor
    assign cursor_prev = cursor_reg - 1'b1;
    assign cur_sector  = data[cursor_reg];
    assign have_prev   = (cursor_reg != '0);
    assign have_next   = ((sstf_pkg::CNT_W'(cursor_reg) + 1'b1) < count_reg);
    assign go_prev     = have_prev && (!have_next || (gap[cursor_prev] < gap[cursor_reg]));

    // count and cursor update
    always_comb
    begin
        count_next  = count_reg;
        cursor_next = cursor_reg;
        if (add_ok)
        begin
            count_next = count_reg + 1'b1;
            if (count_reg == '0)
                cursor_next = '0;
            else if (!lt[cursor_reg])
                cursor_next = cursor_reg + 1'b1;
        end
        else if (del_ok)
        begin
            count_next = count_reg - 1'b1;
            if (count_reg == sstf_pkg::CNT_W'(1))
                cursor_next = '0;
            else if (go_prev)
                cursor_next = cursor_prev;
        end
    end

    // control state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            cursor_reg       <= '0;
            out_valid_reg    <= 1'b0;
            dispatched_reg   <= 1'b0;
            add_rejected_reg <= 1'b0;
            pending_reg      <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
            if (accept)
            begin
                out_valid_reg    <= 1'b1;
                dispatched_reg   <= del_ok;
                add_rejected_reg <= is_add && !add_ok;
                pending_reg      <= count_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
            out_sector_reg <= del_ok ? cur_sector : '0;
    end

    assign out_valid    = out_valid_reg;
    assign dispatched   = dispatched_reg;
    assign add_rejected = add_rejected_reg;
    assign out_sector   = sstf_pkg::PORT_SECTOR_W'(out_sector_reg);
    assign pending      = sstf_pkg::PENDING_W'(pending_reg);

endmodule

[rtl/sstf_checker.sv]
module sstf_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic                                dispatched,
    input logic [sstf_pkg::PORT_SECTOR_W-1:0]  out_sector,
    input logic                                add_rejected,
    input logic [sstf_pkg::PENDING_W-1:0]      pending
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_sector)
            && $stable(pending))
        else $error("result changed while stalled");

    // an item is never both a dispatch and a rejection
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(dispatched && add_rejected))
        else $error("dispatch and reject together");

    // sector is zero unless something was dispatched
    a_zero_sector: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !dispatched |-> out_sector == '0)
        else $error("nonzero sector without dispatch");

    // rejection only with a full table
    a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && add_rejected |->
            pending == sstf_pkg::PENDING_W'(sstf_pkg::QUEUE_DEPTH))
        else $error("reject while table not full");

endmodule

bind sstf_request_scheduler_unit sstf_checker u_sstf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .dispatched   (dispatched),
    .out_sector   (out_sector),
    .add_rejected (add_rejected),
    .pending      (pending)
);
